>>> rtl/assert_macros.svh
// Assertion macros for the edit distance engine RTL.
// Depends on nothing; users provide i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define EDC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define EDC_ASSERT(lbl, prop, msg)
`define EDC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/edc_pkg.sv
// Package for the edit distance engine: sizes, codes and the token that
// travels along the cell chain. Depends on nothing.
package edc_pkg;
    localparam int MAX_LEN  = 64;
    localparam int SYM_BITS = 8;
    localparam int COST_W   = $clog2(MAX_LEN + 1);
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_ROW  = 2'd1;
    localparam logic [1:0] FUNC_FIN  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LONG  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    typedef enum logic [1:0] {
        TK_NONE,
        TK_LOAD,
        TK_ROW,
        TK_FIN
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [SYM_BITS-1:0] sym;
        logic [COST_W-1:0]   left;
        logic [COST_W-1:0]   diag;
        logic                fin_pend;
        logic [1:0]          status;
    } t_token;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [COST_W-1:0] v);
        logic [COST_W:0] ext;
        ext = {1'b0, v};
        if (ext > (COST_W + 1)'(DIST_MAX))
            return DIST_W'(DIST_MAX);
        return DIST_W'(ext);
    endfunction
endpackage

>>> rtl/edc_ifs.sv
// Valid/ready channel interfaces of the edit distance engine.
// Depends on edc_pkg for field widths.
interface edc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] symbol;
    modport source (output valid, output func, output symbol, input ready);
    modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface edc_out_if;
    logic                      valid;
    logic                      ready;
    logic [edc_pkg::DIST_W-1:0] distance;
    logic [1:0]                status;
    modport source (output valid, output distance, output status, input ready);
    modport sink   (input valid, input distance, input status, output ready);
endinterface

>>> rtl/edit_distance_engine_core.sv
// Edit distance engine top: takes one item per cycle into a 64-cell chain
// while the chain does not hold. A finish item's result passes through each
// cell register and then the output register; the chain holds only while a
// result waits and another finish item has reached the end of the chain.
// Synchronous active-low reset clears counters, status and cell flags;
// no clearing pass is needed. Depends on edc_pkg, edc_ifs and edc_array.
`include "assert_macros.svh"
module edit_distance_engine_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    edc_in_if.sink       i_in,
    edc_out_if.source    o_out
);
    logic [edc_pkg::COST_W-1:0] r_ref_len, n_ref_len;
    logic [edc_pkg::COST_W-1:0] r_rows, n_rows;
    logic                       r_pending, n_pending;
    logic [1:0]                 r_status, n_status;
    logic [edc_pkg::COST_W-1:0] r_tail;
    logic                       r_out_valid;
    logic [edc_pkg::DIST_W-1:0] r_dist;
    logic [1:0]                 r_ostat;

    edc_pkg::t_token w_ent;
    edc_pkg::t_token w_tail;
    logic            w_adv;
    logic            w_acc;
    logic            w_fin_acc;
    logic            w_clear;
    logic            w_held;
    logic            w_ref_ok;

    assign w_adv     = !(r_out_valid && !o_out.ready && w_tail.kind == edc_pkg::TK_FIN);
    assign w_acc     = i_in.valid && w_adv;
    assign w_fin_acc = w_acc && i_in.func == edc_pkg::FUNC_FIN;
    assign i_in.ready = w_adv;

    always_comb begin
        n_ref_len = r_ref_len;
        n_rows    = r_rows;
        n_pending = r_pending;
        n_status  = r_status;
        w_ent     = '0;
        w_ent.kind = edc_pkg::TK_NONE;
        if (w_acc) begin
            case (i_in.func)
                edc_pkg::FUNC_LOAD: begin
                    if (!r_pending) begin
                        if (r_status == edc_pkg::ST_OK) n_status = edc_pkg::ST_ORDER;
                    end else if (r_ref_len >= edc_pkg::COST_W'(edc_pkg::MAX_LEN)) begin
                        if (r_status == edc_pkg::ST_OK) n_status = edc_pkg::ST_LONG;
                    end else begin
                        w_ent.kind = edc_pkg::TK_LOAD;
                        w_ent.sym  = i_in.symbol[edc_pkg::SYM_BITS-1:0];
                        n_ref_len  = r_ref_len + 1'b1;
                    end
                end
                edc_pkg::FUNC_ROW: begin
                    n_pending = 1'b0;
                    if (r_rows >= edc_pkg::COST_W'(edc_pkg::MAX_LEN)) begin
                        if (r_status == edc_pkg::ST_OK) n_status = edc_pkg::ST_LONG;
                    end else begin
                        w_ent.kind = edc_pkg::TK_ROW;
                        w_ent.sym  = i_in.symbol[edc_pkg::SYM_BITS-1:0];
                        w_ent.left = r_rows + 1'b1;
                        w_ent.diag = r_rows;
                        n_rows     = r_rows + 1'b1;
                    end
                end
                edc_pkg::FUNC_FIN: begin
                    w_ent.kind     = edc_pkg::TK_FIN;
                    w_ent.left     = r_ref_len;
                    w_ent.fin_pend = r_pending;
                    w_ent.status   = r_status;
                    n_ref_len      = '0;
                    n_rows         = '0;
                    n_pending      = 1'b1;
                    n_status       = edc_pkg::ST_OK;
                end
                default: ;
            endcase
        end
    end

    edc_array u_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tok   (w_ent),
        .o_tok   (w_tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len   <= '0;
            r_rows      <= '0;
            r_pending   <= 1'b1;
            r_status    <= edc_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_ref_len <= n_ref_len;
            r_rows    <= n_rows;
            r_pending <= n_pending;
            r_status  <= n_status;
            if (w_adv && w_tail.kind == edc_pkg::TK_FIN) begin
                r_out_valid <= 1'b1;
                r_dist      <= edc_pkg::sat_dist(w_tail.fin_pend ? w_tail.left : r_tail);
                r_ostat     <= w_tail.status;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv && w_tail.kind == edc_pkg::TK_ROW) r_tail <= w_tail.left;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_dist;
    assign o_out.status   = r_ostat;

    assign w_clear  = r_ref_len == '0 && r_pending && r_status == edc_pkg::ST_OK;
    assign w_held   = r_status != edc_pkg::ST_OK && !w_fin_acc;
    assign w_ref_ok = r_ref_len <= edc_pkg::COST_W'(edc_pkg::MAX_LEN);

    `EDC_ASSERT(a_pend_no_rows, r_pending |-> r_rows == '0, "rows counted before first row")
    `EDC_ASSERT(a_fin_clears, w_fin_acc |=> w_clear, "finish did not clear state")
    `EDC_ASSERT(a_status_sticky, w_held |=> r_status == $past(r_status), "sticky status changed")
    `EDC_ASSERT(a_ref_bound, w_acc |=> w_ref_ok, "reference length overrun")
endmodule

>>> rtl/edc_cell.sv
// One cell of the edit distance chain: holds a reference symbol and its
// column cost, and updates the cost as row tokens pass. Depends on edc_pkg.
module edc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  edc_pkg::t_token i_tok,
    output edc_pkg::t_token o_tok
);
    logic                         r_act;
    logic                         r_fresh;
    logic [edc_pkg::SYM_BITS-1:0] r_sym;
    logic [edc_pkg::COST_W-1:0]   r_cost;
    edc_pkg::t_token              r_out;
    edc_pkg::t_token              n_out;

    logic [edc_pkg::COST_W-1:0]   w_up;
    logic [edc_pkg::COST_W-1:0]   w_m1;
    logic [edc_pkg::COST_W-1:0]   w_m2;
    logic [edc_pkg::COST_W-1:0]   w_cost;

    always_comb begin
        w_up   = r_fresh ? i_tok.diag + 1'b1 : r_cost;
        w_m1   = (i_tok.left < w_up) ? i_tok.left : w_up;
        w_m2   = (w_m1 < i_tok.diag) ? w_m1 : i_tok.diag;
        w_cost = (r_sym == i_tok.sym) ? i_tok.diag : w_m2 + 1'b1;
        n_out  = i_tok;
        if (i_tok.kind == edc_pkg::TK_LOAD && !r_act) n_out.kind = edc_pkg::TK_NONE;
        if (i_tok.kind == edc_pkg::TK_ROW && r_act) begin
            n_out.left = w_cost;
            n_out.diag = w_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_fresh <= 1'b1;
            r_out   <= '0;
        end else if (i_adv) begin
            r_out <= n_out;
            case (i_tok.kind)
                edc_pkg::TK_LOAD: begin
                    if (!r_act) begin
                        r_sym <= i_tok.sym;
                        r_act <= 1'b1;
                    end
                end
                edc_pkg::TK_ROW: begin
                    if (r_act) begin
                        r_cost  <= w_cost;
                        r_fresh <= 1'b0;
                    end
                end
                edc_pkg::TK_FIN: begin
                    r_act   <= 1'b0;
                    r_fresh <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_tok = r_out;
endmodule

>>> rtl/edc_array.sv
// Row of edit distance cells; tokens advance one cell per enabled cycle.
// Depends on edc_pkg and edc_cell.
module edc_array (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  edc_pkg::t_token i_tok,
    output edc_pkg::t_token o_tok
);
    edc_pkg::t_token w_link [edc_pkg::MAX_LEN+1];

    assign w_link[0] = i_tok;

    for (genvar g = 0; g < edc_pkg::MAX_LEN; g++) begin : g_cell
        edc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    assign o_tok = w_link[edc_pkg::MAX_LEN];
endmodule

>>> test/edc_distance_checker.sv
// Checker for the edit distance engine: watches both channels, predicts each distance
// result from the accepted items and compares in order.
// Depends on edc_pkg and the channel interfaces in edc_ifs.
module edc_distance_checker
    import edc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    edc_in_if           i_cmd,
    edc_out_if          i_res,
    output int unsigned o_fail_count,
    output int unsigned o_outstanding
);
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [1:0]        status;
    } t_dist_expect;

    logic [SYM_BITS-1:0] ref_sym [MAX_LEN];
    logic [DIST_W-1:0]   ref_len;
    logic [DIST_W-1:0]   cost_row [MAX_LEN+1];
    logic [DIST_W-1:0]   rows_done;
    logic                row_pending;
    logic [1:0]          sticky;
    t_dist_expect        distance_q [$];
    int unsigned         mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic raise_status(input logic [1:0] code);
        if (sticky == ST_OK) sticky = code;
    endtask

    task automatic clear_pair();
        ref_len     = '0;
        rows_done   = '0;
        row_pending = 1'b1;
        sticky      = ST_OK;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_dist_expect      want;
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] up;
        logic [DIST_W-1:0] cost;
        int                j;
        if (!i_rst_n) begin
            clear_pair();
            distance_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (distance_q.size() == 0) begin
                    report_mismatch("result with none waiting", i_res.distance, 0);
                end else begin
                    want = distance_q.pop_front();
                    if (i_res.distance !== want.distance)
                        report_mismatch("distance", i_res.distance, want.distance);
                    if (i_res.status !== want.status)
                        report_mismatch("status", i_res.status, want.status);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.func)
                    FUNC_LOAD: begin
                        if (!row_pending) begin
                            raise_status(ST_ORDER);
                        end else if (ref_len >= MAX_LEN) begin
                            raise_status(ST_LONG);
                        end else begin
                            ref_sym[ref_len[$clog2(MAX_LEN)-1:0]] = i_cmd.symbol;
                            ref_len = ref_len + 1'b1;
                        end
                    end
                    FUNC_ROW: begin
                        if (row_pending) begin
                            for (j = 0; j <= int'(ref_len); j++) cost_row[j] = DIST_W'(j);
                            row_pending = 1'b0;
                        end
                        if (rows_done >= MAX_LEN) begin
                            raise_status(ST_LONG);
                        end else begin
                            diag        = cost_row[0];
                            cost_row[0] = rows_done + 1'b1;
                            for (j = 1; j <= int'(ref_len); j++) begin
                                up = cost_row[j];
                                if (ref_sym[j-1] == i_cmd.symbol) begin
                                    cost = diag;
                                end else begin
                                    cost = cost_row[j-1];
                                    if (up < cost) cost = up;
                                    if (diag < cost) cost = diag;
                                    cost = cost + 1'b1;
                                end
                                diag        = up;
                                cost_row[j] = cost;
                            end
                            rows_done = rows_done + 1'b1;
                        end
                    end
                    FUNC_FIN: begin
                        want.distance = row_pending ? ref_len : cost_row[ref_len];
                        want.status   = sticky;
                        distance_q.push_back(want);
                        clear_pair();
                    end
                    default: ;
                endcase
            end
        end
        o_outstanding <= distance_q.size();
    end
endmodule

>>> test/tb.sv
// Testbench top for the edit distance engine: drives string pairs and noise under
// varying idling, holds the result side off once, and gives the verdict.
// Depends on edc_pkg, edc_ifs, edit_distance_engine_core and edc_distance_checker.
module tb;
    import edc_pkg::*;

    localparam logic [1:0]  FUNC_NONE    = 2'd3;
    localparam int unsigned RUN_LIMIT    = 500000;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned phase;
    int unsigned sent_items;
    logic [7:0]  palette [4];

    edc_in_if  in_ch ();
    edc_out_if out_ch ();

    edit_distance_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    edc_distance_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (in_ch),
        .i_res         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, one long hold-off early in the last phase
    initial begin
        int unsigned hold_left;
        int unsigned phase3_cycles;
        bit          held;
        hold_left     = 0;
        phase3_cycles = 0;
        held          = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == 3 && !held) phase3_cycles++;
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (phase3_cycles == 50 && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [7:0] sym);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= func;
        in_ch.symbol <= sym;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (func != FUNC_NONE) sent_items++;
    endtask

    function automatic logic [7:0] pick_sym();
        if ($urandom_range(99) < 85) return palette[$urandom_range(3)];
        return 8'($urandom_range(255));
    endfunction

    function automatic int pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(10);
        if (r < 95) return $urandom_range(40, 11);
        return $urandom_range(68, 60);
    endfunction

    task automatic send_pair(input int ref_n, input int row_n, input bit stray);
        int i;
        foreach (palette[k]) palette[k] = 8'($urandom_range(255));
        for (i = 0; i < ref_n; i++) send_item(FUNC_LOAD, pick_sym());
        for (i = 0; i < row_n; i++) begin
            send_item(FUNC_ROW, pick_sym());
            if (stray && i == row_n / 2) send_item(FUNC_LOAD, pick_sym());
        end
        if ($urandom_range(31) == 0) send_item(FUNC_NONE, 8'($urandom_range(255)));
        send_item(FUNC_FIN, 8'($urandom_range(255)));
    endtask

    task automatic run_phase(input int unsigned goal);
        int unsigned r;
        int          n;
        while (sent_items < goal) begin
            r = $urandom_range(99);
            if (r < 8) begin
                for (n = $urandom_range(12, 1); n > 0; n--)
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                send_pair(pick_len(), pick_len(), r < 20);
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_LOAD;
        in_ch.symbol <= '0;
        rx_idle_pct  <= 85;
        phase        <= 1;
        tx_idle_pct   = 7;
        sent_items    = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(FUNC_FIN, 8'h00);
        send_item(FUNC_LOAD, 8'hFF);
        send_item(FUNC_LOAD, 8'h00);
        send_item(FUNC_FIN, 8'h00);
        send_item(FUNC_LOAD, 8'h00);
        send_item(FUNC_LOAD, 8'hFF);
        send_item(FUNC_ROW, 8'hFF);
        send_item(FUNC_ROW, 8'h00);
        send_item(FUNC_FIN, 8'hFF);
        send_item(FUNC_ROW, 8'h55);
        send_item(FUNC_ROW, 8'hAA);
        send_item(FUNC_FIN, 8'h00);
        send_item(FUNC_LOAD, 8'h5A);
        send_item(FUNC_ROW, 8'h5A);
        send_item(FUNC_LOAD, 8'hA5);
        send_item(FUNC_FIN, 8'h00);
        send_item(FUNC_NONE, 8'hFF);
        send_item(FUNC_FIN, 8'hFF);

        send_pair(66, 3, 1'b0);
        send_pair(5, 66, 1'b0);
        send_pair(64, 64, 1'b0);
        send_pair(65, 2, 1'b1);
        run_phase(420);

        tx_idle_pct  = 85;
        rx_idle_pct <= 7;
        phase       <= 2;
        run_phase(790);

        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        phase       <= 3;
        run_phase(1160);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> edit_distance_engine_core.f
+incdir+rtl
rtl/edc_pkg.sv
rtl/edc_ifs.sv
rtl/edc_cell.sv
rtl/edc_array.sv
rtl/edit_distance_engine_core.sv
test/edc_distance_checker.sv
test/tb.sv
